// ----- rtl/leg_contact_state_machine_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the leg contact state machine
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LEG_CONTACT_STATE_MACHINE_TOP_ASSERT_SVH
`define LEG_CONTACT_STATE_MACHINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsm_pkg
// Types and constants shared by the leg contact state machine modules.
// ----------------------------------------------------------------------------
package lcsm_pkg;

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] ADDR_EARLY_TD = 3'd0;
  localparam logic [15:0] EARLY_TD_RESET = 16'd49152;  // 0.75 in Q0.16

  typedef enum logic [2:0] {
    ST_STANCE_NORMAL = 3'd0,
    ST_SLIPPING      = 3'd1,
    ST_LOST          = 3'd2,
    ST_EXPECTING     = 3'd3,
    ST_LATE_LIFTOFF  = 3'd4,
    ST_EARLY_TD      = 3'd5,
    ST_BUMPED        = 3'd6,
    ST_SWING_NORMAL  = 3'd7
  } limb_state_e;

  typedef enum logic [1:0] {
    SG_SUPPORT   = 2'd0,
    SG_INVARIANT = 2'd1,
    SG_RECOVERY  = 2'd2,
    SG_MOTION    = 2'd3
  } limb_strategy_e;

  // Per-leg control state.
  typedef struct packed {
    limb_state_e    mode;
    limb_strategy_e strategy;
    logic           touched_down;
    logic           lifted_off;
    logic           losing;
  } leg_ctrl_t;

  typedef struct packed {
    logic [1:0]         leg_index;
    logic               should_be_grounded;
    logic               is_grounded;
    logic               is_slipping;
    logic [15:0]        swing_phase;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] foot_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_leg;
    logic [2:0]         limb_state;
    logic [1:0]         limb_strategy;
    logic               losing_contact;
    logic signed [31:0] last_contact_x;
    logic signed [31:0] last_contact_y;
    logic signed [31:0] last_contact_z;
    logic signed [31:0] lost_contact_x;
    logic signed [31:0] lost_contact_y;
    logic signed [31:0] lost_contact_z;
  } out_item_t;

endpackage

// ----- rtl/lcsm_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsm_decide
// Contact decision tree: next control state of one leg from its schedule and sensing.
// ----------------------------------------------------------------------------
module lcsm_decide (
  input  lcsm_pkg::leg_ctrl_t cur_i,
  input  logic                want_i,
  input  logic                grounded_i,
  input  logic                slipping_i,
  input  logic [15:0]         phase_i,
  input  logic [15:0]         early_td_i,
  output lcsm_pkg::leg_ctrl_t nxt_o,
  output logic                grab_o,
  output logic                capture_lost_o
);

  lcsm_pkg::leg_ctrl_t nxt;

  always_comb begin
    nxt    = cur_i;
    grab_o = 1'b0;
    if (want_i) begin
      if (grounded_i) begin
        if (slipping_i) begin
          nxt.mode     = lcsm_pkg::ST_SLIPPING;
          nxt.strategy = lcsm_pkg::SG_INVARIANT;
        end else begin
          nxt.mode     = lcsm_pkg::ST_STANCE_NORMAL;
          nxt.strategy = lcsm_pkg::SG_SUPPORT;
          grab_o       = 1'b1;
        end
        nxt.touched_down = 1'b1;
        nxt.lifted_off   = 1'b0;
      end else if (cur_i.touched_down) begin
        // Contact vanished during stance: an ongoing recovery is kept.
        nxt.mode = lcsm_pkg::ST_LOST;
        if (cur_i.strategy != lcsm_pkg::SG_RECOVERY) begin
          nxt.strategy = lcsm_pkg::SG_INVARIANT;
        end
        grab_o = 1'b1;
      end else begin
        nxt.mode     = lcsm_pkg::ST_EXPECTING;
        nxt.strategy = lcsm_pkg::SG_RECOVERY;
      end
    end else begin
      if (grounded_i) begin
        if (!cur_i.lifted_off) begin
          nxt.mode     = lcsm_pkg::ST_LATE_LIFTOFF;
          nxt.strategy = lcsm_pkg::SG_MOTION;
        end else if (phase_i > early_td_i) begin
          nxt.mode         = lcsm_pkg::ST_EARLY_TD;
          nxt.strategy     = lcsm_pkg::SG_SUPPORT;
          nxt.touched_down = 1'b1;
          grab_o           = 1'b1;
        end else begin
          nxt.mode     = lcsm_pkg::ST_BUMPED;
          nxt.strategy = lcsm_pkg::SG_MOTION;
        end
      end else if (cur_i.mode == lcsm_pkg::ST_EARLY_TD || cur_i.mode == lcsm_pkg::ST_LOST) begin
        nxt.mode     = lcsm_pkg::ST_LOST;
        nxt.strategy = lcsm_pkg::SG_RECOVERY;
      end else begin
        nxt.mode         = lcsm_pkg::ST_SWING_NORMAL;
        nxt.strategy     = lcsm_pkg::SG_MOTION;
        nxt.lifted_off   = 1'b1;
        nxt.touched_down = 1'b0;
      end
    end
    nxt.losing = (nxt.mode == lcsm_pkg::ST_LOST);
  end

  // The lost position is taken only on the update where the flag rises.
  assign capture_lost_o = nxt.losing && !cur_i.losing;
  assign nxt_o          = nxt;

endmodule

// ----- rtl/lcsm_leg_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsm_leg_store
// Per-leg state registers with one read and one write port at the same leg.
// ----------------------------------------------------------------------------
module lcsm_leg_store #(
  parameter int NUM_LEGS  = 4,
  parameter int POS_WIDTH = 32,
  localparam int LegIdxW  = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [LegIdxW-1:0]          idx_i,
  output lcsm_pkg::leg_ctrl_t         ctrl_o,
  output logic signed [POS_WIDTH-1:0] contact_o [3],
  output logic signed [POS_WIDTH-1:0] lost_o [3],
  input  logic                        we_i,
  input  lcsm_pkg::leg_ctrl_t         ctrl_i,
  input  logic signed [POS_WIDTH-1:0] contact_i [3],
  input  logic signed [POS_WIDTH-1:0] lost_i [3]
);

  lcsm_pkg::leg_ctrl_t         ctrl_q    [NUM_LEGS];
  logic signed [POS_WIDTH-1:0] contact_q [NUM_LEGS][3];
  logic signed [POS_WIDTH-1:0] lost_q    [NUM_LEGS][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEGS; l++) begin
        ctrl_q[l].mode         <= lcsm_pkg::ST_SWING_NORMAL;
        ctrl_q[l].strategy     <= lcsm_pkg::SG_MOTION;
        ctrl_q[l].touched_down <= 1'b0;
        ctrl_q[l].lifted_off   <= 1'b0;
        ctrl_q[l].losing       <= 1'b0;
        for (int a = 0; a < 3; a++) begin
          contact_q[l][a] <= '0;
          lost_q[l][a]    <= '0;
        end
      end
    end else if (we_i) begin
      ctrl_q[idx_i] <= ctrl_i;
      for (int a = 0; a < 3; a++) begin
        contact_q[idx_i][a] <= contact_i[a];
        lost_q[idx_i][a]    <= lost_i[a];
      end
    end
  end

  always_comb begin
    ctrl_o = ctrl_q[idx_i];
    for (int a = 0; a < 3; a++) begin
      contact_o[a] = contact_q[idx_i][a];
      lost_o[a]    = lost_q[idx_i][a];
    end
  end

endmodule

// ----- rtl/leg_contact_state_machine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_contact_state_machine_top
// Per-leg contact state machine with an APB-style threshold register.
// ----------------------------------------------------------------------------
// Each item for a leg below NUM_LEGS updates that leg and yields exactly one
// result carrying that leg's new limb state, strategy, losing-contact flag
// and its last and lost contact positions; an item whose leg index is not
// below NUM_LEGS is consumed silently. The block takes one item every clock
// cycle while the output side is not stalled. An accepted item first lands
// in the input register; once the result register can take the result, the
// decision tree reads that leg's state, writes the updated state back and
// loads the result register, where the result is valid on the output until
// the output side takes it. The per-leg state registers are read, modified
// and written back in the same update, which also means that back-to-back
// items for the same leg see each other's updates. The result register
// decouples the two sides: a new item is taken while a finished result
// still waits. The early-touchdown threshold lives at byte address 0 of the
// configuration port and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module leg_contact_state_machine_top #(
  parameter int NUM_LEGS  = 4,
  parameter int POS_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Item input.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lcsm_pkg::in_item_t                   in_data_i,
  // Result output.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lcsm_pkg::out_item_t                  out_data_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lcsm_pkg::CfgAddrW-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int LegIdxW = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;

  // Early-touchdown threshold register.
  logic [15:0] early_td_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_td_q <= lcsm_pkg::EARLY_TD_RESET;
    end else if (psel && penable && pwrite && paddr == lcsm_pkg::ADDR_EARLY_TD) begin
      early_td_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == lcsm_pkg::ADDR_EARLY_TD) ? {16'd0, early_td_q} : 32'd0;

  // Input register. It advances whenever the result register can take the
  // result, or straight away for an item that produces none.
  logic               in_valid_q;
  lcsm_pkg::in_item_t in_q;
  logic               leg_ok;
  logic               advance;
  logic               out_valid_q;

  assign leg_ok     = 32'(in_q.leg_index) < 32'(NUM_LEGS);
  assign advance    = in_valid_q && (!leg_ok || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // State lookup and decision for the leg held in the input register.
  logic [LegIdxW-1:0]          leg_sel;
  lcsm_pkg::leg_ctrl_t         cur_ctrl;
  lcsm_pkg::leg_ctrl_t         nxt_ctrl;
  logic                        grab;
  logic                        capture_lost;
  logic signed [POS_WIDTH-1:0] cur_contact [3];
  logic signed [POS_WIDTH-1:0] cur_lost    [3];
  logic signed [POS_WIDTH-1:0] foot_pos    [3];
  logic signed [POS_WIDTH-1:0] new_contact [3];
  logic signed [POS_WIDTH-1:0] new_lost    [3];

  assign leg_sel = LegIdxW'(in_q.leg_index);

  // Positions are held at POS_WIDTH bits: sign-extended or truncated on entry.
  assign foot_pos[0] = POS_WIDTH'($signed(in_q.foot_x));
  assign foot_pos[1] = POS_WIDTH'($signed(in_q.foot_y));
  assign foot_pos[2] = POS_WIDTH'($signed(in_q.foot_z));

  lcsm_leg_store #(
    .NUM_LEGS  (NUM_LEGS),
    .POS_WIDTH (POS_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (leg_sel),
    .ctrl_o    (cur_ctrl),
    .contact_o (cur_contact),
    .lost_o    (cur_lost),
    .we_i      (advance && leg_ok),
    .ctrl_i    (nxt_ctrl),
    .contact_i (new_contact),
    .lost_i    (new_lost)
  );

  lcsm_decide u_decide (
    .cur_i          (cur_ctrl),
    .want_i         (in_q.should_be_grounded),
    .grounded_i     (in_q.is_grounded),
    .slipping_i     (in_q.is_slipping),
    .phase_i        (in_q.swing_phase),
    .early_td_i     (early_td_q),
    .nxt_o          (nxt_ctrl),
    .grab_o         (grab),
    .capture_lost_o (capture_lost)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      new_contact[a] = grab ? foot_pos[a] : cur_contact[a];
      new_lost[a]    = capture_lost ? foot_pos[a] : cur_lost[a];
    end
  end

  // Result register.
  lcsm_pkg::out_item_t out_q;
  lcsm_pkg::out_item_t out_d;

  always_comb begin
    out_d.out_leg        = in_q.leg_index;
    out_d.limb_state     = nxt_ctrl.mode;
    out_d.limb_strategy  = nxt_ctrl.strategy;
    out_d.losing_contact = nxt_ctrl.losing;
    out_d.last_contact_x = 32'($signed(new_contact[0]));
    out_d.last_contact_y = 32'($signed(new_contact[1]));
    out_d.last_contact_z = 32'($signed(new_contact[2]));
    out_d.lost_contact_x = 32'($signed(new_lost[0]));
    out_d.lost_contact_y = 32'($signed(new_lost[1]));
    out_d.lost_contact_z = 32'($signed(new_lost[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && leg_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && leg_ok) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/lcsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsm_checker
// Port-level checks on the results of the leg contact state machine.
// ----------------------------------------------------------------------------
`include "leg_contact_state_machine_top_assert.svh"

module lcsm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lcsm_pkg::out_item_t out_data_o
);

  // A stalled result stays put.
  `LCSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // The losing flag is set exactly while the leg is in lost contact.
  `LCSM_ASSERT_IMPLY(a_losing_matches, clk_i, rst_ni, out_valid_o, out_data_o.losing_contact == (out_data_o.limb_state == lcsm_pkg::ST_LOST), "losing flag disagrees with limb state")

  // Each limb state comes with the strategies the decision tree allows.
  `LCSM_ASSERT_IMPLY(a_strategy_fits, clk_i, rst_ni, out_valid_o, (out_data_o.limb_state == lcsm_pkg::ST_STANCE_NORMAL && out_data_o.limb_strategy == lcsm_pkg::SG_SUPPORT) || (out_data_o.limb_state == lcsm_pkg::ST_EARLY_TD && out_data_o.limb_strategy == lcsm_pkg::SG_SUPPORT) || (out_data_o.limb_state == lcsm_pkg::ST_SLIPPING && out_data_o.limb_strategy == lcsm_pkg::SG_INVARIANT) || (out_data_o.limb_state == lcsm_pkg::ST_EXPECTING && out_data_o.limb_strategy == lcsm_pkg::SG_RECOVERY) || (out_data_o.limb_state == lcsm_pkg::ST_LOST && (out_data_o.limb_strategy == lcsm_pkg::SG_INVARIANT || out_data_o.limb_strategy == lcsm_pkg::SG_RECOVERY)) || ((out_data_o.limb_state == lcsm_pkg::ST_LATE_LIFTOFF || out_data_o.limb_state == lcsm_pkg::ST_BUMPED || out_data_o.limb_state == lcsm_pkg::ST_SWING_NORMAL) && out_data_o.limb_strategy == lcsm_pkg::SG_MOTION), "limb strategy does not fit limb state")

endmodule

bind leg_contact_state_machine_top lcsm_checker u_lcsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
